@@ hw/rtl/nsp_pkg.sv @@
// nsp_pkg: shared types, constants and helpers of the NMEA sentence parser.
// Used by nsp_front, nsp_back and the top level; depends on nothing.
package nsp_pkg;

   localparam int MAX_FRAC_DIGITS = 5;
   localparam int MIN_LINE_LEN    = 9;

   localparam int SUM_W  = 35;
   localparam int FRAC_W = 24;

   localparam logic [39:0] KEY_GLL = 40'h4750474C4C;
   localparam logic [39:0] KEY_GSV = 40'h4750475356;
   localparam logic [39:0] KEY_GSA = 40'h4750475341;

   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_COMMA = 8'd44;
   localparam logic [7:0] CH_DOT   = 8'd46;

   localparam logic [23:0] E7 = 24'd10000000;
   localparam logic [19:0] E6 = 20'd1000000;
   localparam logic [34:0] LAT_LIMIT = 35'd999999999;
   localparam logic [34:0] LON_LIMIT = 35'd1999999999;

   // ceil(2^16 / 6) and ceil(2^29 / 15)
   localparam logic [13:0] DIV6_RECIP  = 14'd10923;
   localparam logic [25:0] DIV15_RECIP = 26'd35791395;

   localparam logic [1:0] PH_INT  = 2'd0;
   localparam logic [1:0] PH_FRAC = 2'd1;
   localparam logic [1:0] PH_STOP = 2'd2;

   typedef enum logic [1:0] {
      KIND_GLL = 2'd0,
      KIND_GSV = 2'd1,
      KIND_GSA = 2'd2
   } kind_type;

   typedef struct packed {
      logic [9:0]        deg;
      logic              deg_ok;
      logic              deg_done;
      logic [13:0]       mint;
      logic [FRAC_W-1:0] mfrac;
      logic [2:0]        nfrac;
      logic [1:0]        phase;
      logic              mdig;
      logic [7:0]        len;
   } coord_type;

   typedef struct packed {
      kind_type          kind;
      logic [9:0]        lat_deg;
      logic [13:0]       lat_mint;
      logic [FRAC_W-1:0] lat_mfrac;
      logic [2:0]        lat_nfrac;
      logic [9:0]        lon_deg;
      logic [13:0]       lon_mint;
      logic [FRAC_W-1:0] lon_mfrac;
      logic [2:0]        lon_nfrac;
      logic [7:0]        view;
      logic [3:0]        in_use;
   } job_type;

   typedef struct packed {
      kind_type    kind;
      logic [29:0] lat;
      logic [30:0] lon;
      logic [7:0]  view;
      logic [3:0]  in_use;
   } result_type;

   function automatic logic [23:0] pow10(input logic [2:0] n);
      logic [23:0] r;
      case (n)
         3'd0: r = 24'd1;
         3'd1: r = 24'd10;
         3'd2: r = 24'd100;
         3'd3: r = 24'd1000;
         3'd4: r = 24'd10000;
         3'd5: r = 24'd100000;
         3'd6: r = 24'd1000000;
         default: r = 24'd10000000;
      endcase
      return r;
   endfunction

endpackage

@@ hw/rtl/nsp_fifo.sv @@
// nsp_fifo: small register queue, used for sentence requests and for results.
// Depends on nothing.
module nsp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("queue count overflow");
   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue pop lost");
   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      !(full && empty)) else $error("queue full and empty at once");
endmodule

@@ hw/rtl/nsp_front.sv @@
// nsp_front: takes text bytes, tracks line, key and fields, and builds one
// request per usable sentence. Depends on nsp_pkg.
module nsp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic             full,
   input  logic [7:0]       rx_byte,
   output logic             job_push,
   output nsp_pkg::job_type job_data
);
   logic [7:0]  line_len_ff, line_len_in;
   logic [39:0] key_ff, key_in;
   logic [4:0]  fidx_ff, fidx_in;
   logic [7:0]  fcc_ff, fcc_in;
   nsp_pkg::coord_type lat_ff, lat_in, lon_ff, lon_in;
   logic [7:0]  view_ff, view_in;
   logic        view_ok_ff, view_ok_in, view_done_ff, view_done_in;
   logic [3:0]  slot_ff, slot_in;
   logic        accept, eol, is_dig;
   logic [11:0] view_sum;
   logic        lat_ok, lon_ok;

   function automatic nsp_pkg::coord_type coord_feed(input nsp_pkg::coord_type a,
         input logic [7:0] c, input logic [7:0] idx, input logic [1:0] degw);
      nsp_pkg::coord_type r;
      logic dig;
      logic [3:0] d;
      logic [16:0] mi;
      r   = a;
      dig = (c >= 8'd48) && (c <= 8'd57);
      d   = c[3:0];
      mi  = 17'(a.mint) * 17'd10 + 17'(d);
      if (r.len != 8'd255) r.len = r.len + 1'b1;
      if (idx < {6'd0, degw}) begin
         if (!r.deg_done) begin
            if (dig) begin
               r.deg    = 10'(r.deg * 10'd10) + {6'd0, d};
               r.deg_ok = 1'b1;
            end else begin
               r.deg_done = 1'b1;
            end
         end
      end else begin
         case (r.phase)
            nsp_pkg::PH_INT: begin
               if (dig) begin
                  r.mint = (mi > 17'd9999) ? 14'd9999 : mi[13:0];
                  r.mdig = 1'b1;
               end else if (c == nsp_pkg::CH_DOT) begin
                  r.phase = nsp_pkg::PH_FRAC;
               end else begin
                  r.phase = nsp_pkg::PH_STOP;
               end
            end
            nsp_pkg::PH_FRAC: begin
               if (dig) begin
                  if (r.nfrac < 3'(nsp_pkg::MAX_FRAC_DIGITS)) begin
                     r.mfrac = nsp_pkg::FRAC_W'(r.mfrac * 24'd10) + {20'd0, d};
                     r.nfrac = r.nfrac + 1'b1;
                  end
                  r.mdig = 1'b1;
               end else begin
                  r.phase = nsp_pkg::PH_STOP;
               end
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   assign accept   = push && !full;
   assign eol      = (rx_byte == nsp_pkg::CH_LF) || (rx_byte == nsp_pkg::CH_CR);
   assign is_dig   = (rx_byte >= 8'd48) && (rx_byte <= 8'd57);
   assign view_sum = 12'(view_ff) * 12'd10 + {8'd0, rx_byte[3:0]};
   assign lat_ok   = (lat_ff.len > 8'd2) && lat_ff.deg_ok && lat_ff.mdig;
   assign lon_ok   = (lon_ff.len > 8'd2) && lon_ff.deg_ok && lon_ff.mdig;

   always_comb begin
      job_data.lat_deg   = lat_ff.deg;
      job_data.lat_mint  = lat_ff.mint;
      job_data.lat_mfrac = lat_ff.mfrac;
      job_data.lat_nfrac = lat_ff.nfrac;
      job_data.lon_deg   = lon_ff.deg;
      job_data.lon_mint  = lon_ff.mint;
      job_data.lon_mfrac = lon_ff.mfrac;
      job_data.lon_nfrac = lon_ff.nfrac;
      job_data.view      = view_ff;
      job_data.in_use    = slot_ff;
      job_data.kind      = nsp_pkg::KIND_GSA;
      job_push           = 1'b0;
      if (accept && eol && (line_len_ff >= 8'(nsp_pkg::MIN_LINE_LEN))) begin
         if (key_ff == nsp_pkg::KEY_GLL) begin
            job_data.kind = nsp_pkg::KIND_GLL;
            job_push      = lat_ok && lon_ok;
         end else if (key_ff == nsp_pkg::KEY_GSV) begin
            job_data.kind = nsp_pkg::KIND_GSV;
            job_push      = (fidx_ff >= 5'd4) && view_ok_ff;
         end else if (key_ff == nsp_pkg::KEY_GSA) begin
            job_push      = 1'b1;
         end
      end
   end

   always_comb begin
      line_len_in  = line_len_ff;
      key_in       = key_ff;
      fidx_in      = fidx_ff;
      fcc_in       = fcc_ff;
      lat_in       = lat_ff;
      lon_in       = lon_ff;
      view_in      = view_ff;
      view_ok_in   = view_ok_ff;
      view_done_in = view_done_ff;
      slot_in      = slot_ff;
      if (accept) begin
         if (eol) begin
            line_len_in  = '0;
            key_in       = '0;
            fidx_in      = '0;
            fcc_in       = '0;
            lat_in       = '0;
            lon_in       = '0;
            view_in      = '0;
            view_ok_in   = 1'b0;
            view_done_in = 1'b0;
            slot_in      = '0;
         end else begin
            if (line_len_ff != 8'd255) line_len_in = line_len_ff + 1'b1;
            if ((line_len_ff >= 8'd1) && (line_len_ff <= 8'd5)) begin
               key_in = {key_ff[31:0], rx_byte};
            end
            if (line_len_ff >= 8'd7) begin
               if (rx_byte == nsp_pkg::CH_COMMA) begin
                  if (fidx_ff != 5'd31) fidx_in = fidx_ff + 1'b1;
                  fcc_in = '0;
               end else begin
                  if ((fidx_ff >= 5'd2) && (fidx_ff <= 5'd13) && (fcc_ff == 8'd0)) begin
                     slot_in = slot_ff + 1'b1;
                  end
                  if (fidx_ff == 5'd0) lat_in = coord_feed(lat_ff, rx_byte, fcc_ff, 2'd2);
                  if (fidx_ff == 5'd2) begin
                     lon_in = coord_feed(lon_ff, rx_byte, fcc_ff, 2'd3);
                     if (!view_done_ff) begin
                        if (is_dig) begin
                           view_in    = (view_sum > 12'd255) ? 8'd255 : view_sum[7:0];
                           view_ok_in = 1'b1;
                        end else begin
                           view_done_in = 1'b1;
                        end
                     end
                  end
                  if (fcc_ff != 8'd255) fcc_in = fcc_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_len_ff  <= '0;
         key_ff       <= '0;
         fidx_ff      <= '0;
         fcc_ff       <= '0;
         lat_ff       <= '0;
         lon_ff       <= '0;
         view_ff      <= '0;
         view_ok_ff   <= 1'b0;
         view_done_ff <= 1'b0;
         slot_ff      <= '0;
      end else begin
         line_len_ff  <= line_len_in;
         key_ff       <= key_in;
         fidx_ff      <= fidx_in;
         fcc_ff       <= fcc_in;
         lat_ff       <= lat_in;
         lon_ff       <= lon_in;
         view_ff      <= view_in;
         view_ok_ff   <= view_ok_in;
         view_done_ff <= view_done_in;
         slot_ff      <= slot_in;
      end
   end

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= 4'd12) else $error("slot count beyond twelve");
   a_eol_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && eol) |=> (line_len_ff == 8'd0 && fidx_ff == 5'd0))
      else $error("line state not cleared");
   a_fields_late: assert property (@(posedge clock) disable iff (reset)
      (line_len_ff < 8'd7) |-> (fidx_ff == 5'd0))
      else $error("field count moved inside the header");
endmodule

@@ hw/rtl/nsp_back.sv @@
// nsp_back: executes sentence requests; converts coordinates with reciprocal
// multiplications for the divide by sixty and keeps the held values. Depends on nsp_pkg.
module nsp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_empty,
   input  nsp_pkg::job_type    job_data,
   output logic                job_pop,
   input  logic                res_full,
   output logic                res_push,
   output nsp_pkg::result_type res_data
);
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_MUL  = 6'b000010,
      S_SUM  = 6'b000100,
      S_DIV  = 6'b001000,
      S_ADD  = 6'b010000,
      S_EMIT = 6'b100000
   } state_type;

   localparam int SW = nsp_pkg::SUM_W;

   state_type        state_ff, state_in;
   nsp_pkg::job_type job_ff;
   logic             lon_sel_ff;
   logic [SW-1:0]    deg_prod_ff;
   logic [10:0]      six_ff;
   logic [23:0]      frac_ff;
   logic [30:0]      six_prod_ff;
   logic [24:0]      quarter_ff;
   logic [19:0]      quot_ff;
   logic [29:0]      lat_res_ff, held_lat_ff, held_lat_in;
   logic [30:0]      lon_res_ff, held_lon_ff, held_lon_in;
   logic [7:0]       held_view_ff, held_view_in;
   logic [3:0]       held_use_ff, held_use_in;
   logic [27:0]      six_mul;
   logic [13:0]      six_rem;
   logic [26:0]      low_num;
   logic [50:0]      recip_prod;
   logic [SW-1:0]    sum, sat, limit;
   logic [9:0]       sel_deg;
   logic [13:0]      sel_mint;
   logic [23:0]      sel_mfrac;
   logic [2:0]       sel_nfrac;

   // minutes = 6a + b; value = deg*1e7 + a*1e6 + (b*1e7 + frac) / 60
   assign six_mul    = 28'(sel_mint) * 28'(nsp_pkg::DIV6_RECIP);
   assign six_rem    = sel_mint - 14'(14'(six_ff) * 14'd6);
   assign low_num    = 27'(six_rem[2:0]) * 27'(nsp_pkg::E7) + 27'(frac_ff);
   assign recip_prod = 51'(quarter_ff) * 51'(nsp_pkg::DIV15_RECIP);
   assign sum        = deg_prod_ff + SW'(six_prod_ff) + SW'(quot_ff);
   assign limit      = lon_sel_ff ? nsp_pkg::LON_LIMIT : nsp_pkg::LAT_LIMIT;
   assign sat        = (sum > limit) ? limit : sum;
   assign sel_deg    = lon_sel_ff ? job_ff.lon_deg   : job_ff.lat_deg;
   assign sel_mint   = lon_sel_ff ? job_ff.lon_mint  : job_ff.lat_mint;
   assign sel_mfrac  = lon_sel_ff ? job_ff.lon_mfrac : job_ff.lat_mfrac;
   assign sel_nfrac  = lon_sel_ff ? job_ff.lon_nfrac : job_ff.lat_nfrac;

   always_comb begin
      state_in     = state_ff;
      job_pop      = 1'b0;
      res_push     = 1'b0;
      held_lat_in  = held_lat_ff;
      held_lon_in  = held_lon_ff;
      held_view_in = held_view_ff;
      held_use_in  = held_use_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               state_in = (job_data.kind == nsp_pkg::KIND_GLL) ? S_MUL : S_EMIT;
            end
         end
         S_MUL: state_in = S_SUM;
         S_SUM: state_in = S_DIV;
         S_DIV: state_in = S_ADD;
         S_ADD: state_in = lon_sel_ff ? S_EMIT : S_MUL;
         S_EMIT: begin
            if (!res_full) begin
               res_push = 1'b1;
               state_in = S_IDLE;
               case (job_ff.kind)
                  nsp_pkg::KIND_GLL: begin
                     held_lat_in = lat_res_ff;
                     held_lon_in = lon_res_ff;
                  end
                  nsp_pkg::KIND_GSV: held_view_in = job_ff.view;
                  default:           held_use_in  = job_ff.in_use;
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      res_data.kind   = job_ff.kind;
      res_data.lat    = held_lat_in;
      res_data.lon    = held_lon_in;
      res_data.view   = held_view_in;
      res_data.in_use = held_use_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_lat_ff  <= '0;
         held_lon_ff  <= '0;
         held_view_ff <= '0;
         held_use_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         held_lat_ff  <= held_lat_in;
         held_lon_ff  <= held_lon_in;
         held_view_ff <= held_view_in;
         held_use_ff  <= held_use_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff     <= job_data;
         lon_sel_ff <= 1'b0;
      end
      if (state_ff == S_MUL) begin
         six_ff      <= six_mul[26:16];
         frac_ff     <= 24'(sel_mfrac * nsp_pkg::pow10(3'd7 - sel_nfrac));
         deg_prod_ff <= SW'(sel_deg) * SW'(nsp_pkg::E7);
      end
      if (state_ff == S_SUM) begin
         quarter_ff  <= low_num[26:2];
         six_prod_ff <= 31'(six_ff) * 31'(nsp_pkg::E6);
      end
      if (state_ff == S_DIV) begin
         quot_ff <= recip_prod[48:29];
      end
      if (state_ff == S_ADD) begin
         if (lon_sel_ff) begin
            lon_res_ff <= sat[30:0];
         end else begin
            lat_res_ff <= sat[29:0];
            lon_sel_ff <= 1'b1;
         end
      end
   end

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |=> (state_ff == S_ADD))
      else $error("divider left early");
   a_sum_next: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM) |=> (state_ff == S_DIV)) else $error("sum stage skipped");
   a_gll_both: assert property (@(posedge clock) disable iff (reset)
      (res_push && job_ff.kind == nsp_pkg::KIND_GLL) |-> lon_sel_ff)
      else $error("location emitted before longitude");
endmodule

@@ hw/rtl/nmea_sentence_parser_unit.sv @@
// nmea_sentence_parser_unit: top level; front, request queue, back, result queue.
// Takes one byte per cycle while the request queue has room. The back emits a
// GSV/GSA result directly; a GLL result first takes two coordinate passes.
// The back takes one sentence at a time; a 2-deep request queue decouples it,
// and the input stalls only while that queue is full.
// Synchronous active-high reset clears line state and zeroes held values.
// Depends on nsp_pkg, nsp_fifo, nsp_front, nsp_back.
module nmea_sentence_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_rx_byte,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_update_kind,
   output logic [29:0] rsp_latitude_e7,
   output logic [30:0] rsp_longitude_e7,
   output logic [7:0]  rsp_sats_in_view,
   output logic [3:0]  rsp_sats_in_use
);
   nsp_pkg::job_type    job_wr, job_rd;
   nsp_pkg::result_type res_wr, res_rd;
   logic job_push, job_pop, job_empty, res_push, res_full;

   nsp_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .rx_byte(req_rx_byte), .job_push(job_push), .job_data(job_wr)
   );

   nsp_fifo #(.WIDTH($bits(nsp_pkg::job_type)), .DEPTH(2)) u_job_q (
      .clock(clock), .reset(reset), .push(job_push), .wr_data(job_wr), .full(full),
      .pop(job_pop), .rd_data(job_rd), .empty(job_empty)
   );

   nsp_back u_back (
      .clock(clock), .reset(reset), .job_empty(job_empty), .job_data(job_rd),
      .job_pop(job_pop), .res_full(res_full), .res_push(res_push), .res_data(res_wr)
   );

   nsp_fifo #(.WIDTH($bits(nsp_pkg::result_type)), .DEPTH(2)) u_res_q (
      .clock(clock), .reset(reset), .push(res_push), .wr_data(res_wr), .full(res_full),
      .pop(pop), .rd_data(res_rd), .empty(empty)
   );

   assign rsp_update_kind  = res_rd.kind;
   assign rsp_latitude_e7  = res_rd.lat;
   assign rsp_longitude_e7 = res_rd.lon;
   assign rsp_sats_in_view = res_rd.view;
   assign rsp_sats_in_use  = res_rd.in_use;
endmodule

@@ tb/tb.sv @@
// tb: self-checking testbench for nmea_sentence_parser_unit.
// Drives NMEA text one byte per request and predicts each update in SV.
// Depends on nsp_pkg and nmea_sentence_parser_unit.
`timescale 1ns / 100ps
module tb;

   typedef struct {
      int unsigned deg;
      bit          deg_ok;
      bit          deg_done;
      int unsigned mint;
      int unsigned mfrac;
      int unsigned nfrac;
      int unsigned phase;
      bit          mdig;
      int unsigned len;
   } coord_acc_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        push = 0;
   logic        full;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        empty;
   logic        pop = 0;
   logic [1:0]  rsp_update_kind;
   logic [29:0] rsp_latitude_e7;
   logic [30:0] rsp_longitude_e7;
   logic [7:0]  rsp_sats_in_view;
   logic [3:0]  rsp_sats_in_use;

   nmea_sentence_parser_unit DUT (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // parser state
   int unsigned line_len, fld_idx, fld_chars, view_val, slot_cnt;
   logic [39:0] key_sr;
   coord_acc_type lat_acc, lon_acc;
   bit          view_ok, view_done;
   longint unsigned held_lat, held_lon;
   int unsigned held_view, held_use;

   nsp_pkg::result_type pending_updates[$];
   int          errors = 0;
   bit          no_idle = 0;
   int          rsp_hold = 0;
   int          idle_cycles = 0;

   function automatic bit is_dig(int unsigned c);
      return c >= 48 && c <= 57;
   endfunction

   function automatic longint unsigned ten_pow(int unsigned n);
      longint unsigned p = 1;
      repeat (n) p *= 10;
      return p;
   endfunction

   function automatic void feed_coord(inout coord_acc_type a, input int unsigned c,
                                      input int unsigned idx, input int unsigned degw);
      if (a.len < 255) a.len++;
      if (idx < degw) begin
         if (!a.deg_done) begin
            if (is_dig(c)) begin
               a.deg = a.deg * 10 + c - 48;
               a.deg_ok = 1;
            end else a.deg_done = 1;
         end
      end else if (a.phase == 0) begin
         if (is_dig(c)) begin
            a.mint = a.mint * 10 + c - 48;
            if (a.mint > 9999) a.mint = 9999;
            a.mdig = 1;
         end else if (c == nsp_pkg::CH_DOT) a.phase = 1;
         else a.phase = 2;
      end else if (a.phase == 1) begin
         if (is_dig(c)) begin
            if (a.nfrac < nsp_pkg::MAX_FRAC_DIGITS) begin
               a.mfrac = a.mfrac * 10 + c - 48;
               a.nfrac++;
            end
            a.mdig = 1;
         end else a.phase = 2;
      end
   endfunction

   function automatic bit coord_e7(input coord_acc_type a, input longint unsigned lim,
                                   output longint unsigned v);
      longint unsigned scale, m, r;
      v = 0;
      if (a.len <= 2 || !a.deg_ok || !a.mdig) return 0;
      scale = ten_pow(nsp_pkg::MAX_FRAC_DIGITS);
      m = a.mint * scale + a.mfrac * ten_pow(nsp_pkg::MAX_FRAC_DIGITS - a.nfrac);
      r = longint'(a.deg) * 10000000 + (m * 10000000) / (60 * scale);
      v = r > lim ? lim : r;
      return 1;
   endfunction

   function automatic void clear_line();
      line_len = 0; key_sr = '0; fld_idx = 0; fld_chars = 0;
      lat_acc = '{default: 0}; lon_acc = '{default: 0};
      view_val = 0; view_ok = 0; view_done = 0; slot_cnt = 0;
   endfunction

   function automatic void parse_byte(input logic [7:0] b);
      int unsigned c = b;
      int unsigned pos = line_len;
      bit hit = 0;
      nsp_pkg::kind_type k = nsp_pkg::KIND_GLL;
      longint unsigned la, lo;
      nsp_pkg::result_type r;
      if (b == nsp_pkg::CH_LF || b == nsp_pkg::CH_CR) begin
         if (line_len >= nsp_pkg::MIN_LINE_LEN) begin
            if (key_sr == nsp_pkg::KEY_GLL) begin
               if (coord_e7(lat_acc, 999999999, la) && coord_e7(lon_acc, 1999999999, lo)) begin
                  held_lat = la; held_lon = lo; hit = 1; k = nsp_pkg::KIND_GLL;
               end
            end else if (key_sr == nsp_pkg::KEY_GSV) begin
               if (fld_idx >= 4 && view_ok) begin
                  held_view = view_val; hit = 1; k = nsp_pkg::KIND_GSV;
               end
            end else if (key_sr == nsp_pkg::KEY_GSA) begin
               held_use = slot_cnt; hit = 1; k = nsp_pkg::KIND_GSA;
            end
         end
         clear_line();
         if (hit) begin
            r.kind = k; r.lat = held_lat[29:0]; r.lon = held_lon[30:0];
            r.view = held_view[7:0]; r.in_use = held_use[3:0];
            pending_updates = {pending_updates, r};
         end
         return;
      end
      if (line_len < 255) line_len++;
      if (pos >= 1 && pos <= 5) key_sr = {key_sr[31:0], b};
      if (pos < 7) return;
      if (b == nsp_pkg::CH_COMMA) begin
         if (fld_idx < 31) fld_idx++;
         fld_chars = 0;
         return;
      end
      if (fld_idx >= 2 && fld_idx <= 13 && fld_chars == 0) slot_cnt++;
      if (fld_idx == 0) feed_coord(lat_acc, c, fld_chars, 2);
      if (fld_idx == 2) begin
         feed_coord(lon_acc, c, fld_chars, 3);
         if (!view_done) begin
            if (is_dig(c)) begin
               view_val = view_val * 10 + c - 48;
               if (view_val > 255) view_val = 255;
               view_ok = 1;
            end else view_done = 1;
         end
      end
      if (fld_chars < 255) fld_chars++;
   endfunction

   // one request per byte
   task automatic send_byte(input logic [7:0] b);
      int gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         push <= 0;
         repeat (gap) @(posedge clock);
      end
      push <= 1;
      req_rx_byte <= b;
      do @(posedge clock); while (full);
      parse_byte(b);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic wait_drained();
      push <= 0;
      @(posedge clock);
      wait (pending_updates.size() == 0);
      repeat (100) @(posedge clock);
   endtask

   function automatic string rand_digits(int n);
      string s = "";
      for (int i = 0; i < n; i++) s = {s, string'(byte'(48 + $urandom_range(0, 9)))};
      return s;
   endfunction

   function automatic string rand_field();
      string s = "";
      int n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++)
         s = {s, string'(byte'($urandom_range(0, 3) == 0 ?
                               $urandom_range(32, 126) : 48 + $urandom_range(0, 9)))};
      for (int i = 0; i < s.len(); i++) if (s[i] == ",") s[i] = "5";
      return s;
   endfunction

   function automatic string rand_coord(int degw);
      string s;
      case ($urandom_range(0, 9))
         0: return rand_field();
         1: return rand_digits($urandom_range(0, 3));
         default: begin
            s = {rand_digits(degw), rand_digits($urandom_range(0, 5))};
            if ($urandom_range(0, 4) != 0) s = {s, ".", rand_digits($urandom_range(0, 9))};
            if ($urandom_range(0, 7) == 0) s = {s, "x", rand_digits(2)};
            return s;
         end
      endcase
   endfunction

   function automatic string line_end();
      case ($urandom_range(0, 2))
         0: return "\r\n";
         1: return "\n";
         default: return "\r";
      endcase
   endfunction

   function automatic string rand_sentence();
      string s;
      int n;
      case ($urandom_range(0, 9))
         0, 1, 2: s = {"$GPGLL,", rand_coord(2), ",N,", rand_coord(3), ",E,123519,A"};
         3, 4: begin
            s = {"$GPGSV,", rand_digits(1), ",", rand_digits(1), ","};
            s = {s, $urandom_range(0, 5) == 0 ? rand_field() : rand_digits($urandom_range(1, 4))};
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) s = {s, ",", rand_field()};
         end
         5, 6, 7: begin
            s = "$GPGSA,A,3";
            n = $urandom_range(0, 16);
            for (int i = 0; i < n; i++)
               s = {s, ",", $urandom_range(0, 2) == 0 ? "" : rand_digits($urandom_range(1, 2))};
         end
         8: s = {"$GPRMC,", rand_field(), ",", rand_field()};
         default: s = {"$GP", rand_field()};
      endcase
      if ($urandom_range(0, 1)) s = {s, "*", rand_digits(2)};
      return {s, line_end()};
   endfunction

   task automatic test_gll();
      send_text("$GPGLL,4916.45,N,12311.12,W,225444,A\r\n");
      send_text("$GPGLL,9959.9999999,S,17959.9999999,E\n");
      send_text("$GPGLL,99999999.9,N,999999999.9,E\r");
      send_text("$GPGLL,12,N,12345.6,E\n");
      send_text("$GPGLL,4916.45,N,123,E\n");
      send_text("$GPGLL,-49.5,N,+12311,E\n");
      send_text("$GPGLL,4916.,N,12311.x,E\n");
      send_text("$GPGLL,0000.00000,N,00000.0,W\n");
      send_text("$GPGLL,4916.45\n");
   endtask

   task automatic test_gsv();
      send_text("$GPGSV,3,1,11,03,03,111,00\r\n");
      send_text("$GPGSV,3,1,999,03\n");
      send_text("$GPGSV,3,1,07\n");
      send_text("$GPGSV,3,1,,03,04\n");
      send_text("$GPGSV,3,1, 5,03,04\n");
   endtask

   task automatic test_gsa();
      send_text("$GPGSA,A,3,04,05,,09,12,,,24,,,,,2.5,1.3,2.1*39\r\n");
      send_text("$GPGSA,A,3,1,2,3,4,5,6,7,8,9,10,11,12,13,14\n");
      send_text("$GPGSA,A\n");
      send_text("$GPGSA,A,3,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,1,2\n");
   endtask

   task automatic test_rejects();
      string s = "$GPGSA,A,3,";
      for (int i = 0; i < 300; i++) s = {s, "7"};
      send_text({s, "\n"});
      send_text("$GPGSA,\n");
      send_text("$GPGSA,A\n");
      send_text("$GPRMC,1,2,3,4,5\n");
      send_text("\r\n\n");
      send_byte(8'hFF); send_byte(8'h00); send_byte(8'hAA); send_byte(8'h55);
      send_byte(nsp_pkg::CH_LF);
   endtask

   task automatic test_random(input int n_bytes);
      int sent = 0;
      int n;
      string s;
      while (sent < n_bytes) begin
         no_idle = ($urandom_range(0, 7) == 0);
         if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 20);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
            sent += n;
         end else begin
            s = rand_sentence();
            send_text(s);
            sent += s.len();
         end
      end
      no_idle = 0;
   endtask

   task automatic test_backpressure();
      rsp_hold = 400;
      no_idle = 1;
      repeat (12) send_text("$GPGSA,A,3,04,05,,09\n");
      no_idle = 0;
      wait_drained();
   endtask

   // result checking
   always @(posedge clock) begin
      nsp_pkg::result_type want;
      if (!reset && pop && !empty) begin
         if (pending_updates.size() == 0) begin
            errors++;
            $display("%0t: unexpected update kind %0d", $time, rsp_update_kind);
         end else begin
            want = pending_updates.pop_front();
            if (rsp_update_kind !== want.kind) begin
               errors++;
               $display("%0t: kind exp %0d got %0d", $time, want.kind, rsp_update_kind);
            end
            if (rsp_latitude_e7 !== want.lat) begin
               errors++;
               $display("%0t: lat exp %0d got %0d", $time, want.lat, rsp_latitude_e7);
            end
            if (rsp_longitude_e7 !== want.lon) begin
               errors++;
               $display("%0t: lon exp %0d got %0d", $time, want.lon, rsp_longitude_e7);
            end
            if (rsp_sats_in_view !== want.view) begin
               errors++;
               $display("%0t: view exp %0d got %0d", $time, want.view, rsp_sats_in_view);
            end
            if (rsp_sats_in_use !== want.in_use) begin
               errors++;
               $display("%0t: in use exp %0d got %0d", $time, want.in_use, rsp_sats_in_use);
            end
         end
      end
   end

   // result side stalls
   always @(posedge clock) begin
      int stall;
      if (reset) begin
         pop <= 0;
         stall = 0;
      end else begin
         if (pop && !empty) stall = no_idle ? 0 : $urandom_range(0, 5);
         if (rsp_hold > 0) begin
            rsp_hold--;
            pop <= 0;
         end else if (stall > 0) begin
            stall--;
            pop <= 0;
         end else pop <= 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("** nmea_sentence_parser_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      held_lat = 0; held_lon = 0; held_view = 0; held_use = 0;
      clear_line();
      repeat (8) @(posedge clock);
      reset <= 0;
      test_gll();
      test_gsv();
      test_gsa();
      test_rejects();
      wait_drained();
      test_backpressure();
      test_random(500);
      wait_drained();
      if (errors == 0) $display("** nmea_sentence_parser_unit: PASSED **");
      else $display("** nmea_sentence_parser_unit: FAILED **");
      $finish;
   end
endmodule
